/* rtl/core/pts_pkg.sv */
// Shared types, codes and the bytes-per-pixel table for the pixel transfer size check.
// No dependencies; used by pixel_transfer_size_check.
`default_nettype none

package pts_pkg;

   // Result status codes, in check order
   typedef enum logic [2:0] {
      STATUS_OK             = 3'd0,
      STATUS_NEG_EXTENT     = 3'd1,
      STATUS_BAD_LAYOUT     = 3'd2,
      STATUS_FORBIDDEN_TYPE = 3'd3,
      STATUS_BAD_STORE      = 3'd4,
      STATUS_SKIP_OVERRUN   = 3'd5,
      STATUS_RANGE          = 3'd6
   } status_type;

   // Pixel-store register indexes
   typedef enum logic [2:0] {
      REG_ROW_ALIGNMENT = 3'd0,
      REG_ROW_LENGTH    = 3'd1,
      REG_SKIP_ROWS     = 3'd2,
      REG_SKIP_PIXELS   = 3'd3,
      REG_IMAGE_ROWS    = 3'd4,
      REG_SKIP_IMAGES   = 3'd5
   } reg_index_type;

   localparam logic [3:0] ALIGN_RESET = 4'd4;

   // Format codes
   localparam logic [3:0] FMT_ALPHA         = 4'd0;
   localparam logic [3:0] FMT_LUMINANCE     = 4'd1;
   localparam logic [3:0] FMT_RED           = 4'd2;
   localparam logic [3:0] FMT_RED_INT       = 4'd3;
   localparam logic [3:0] FMT_DEPTH         = 4'd4;
   localparam logic [3:0] FMT_LUM_ALPHA     = 4'd5;
   localparam logic [3:0] FMT_RG            = 4'd6;
   localparam logic [3:0] FMT_RG_INT        = 4'd7;
   localparam logic [3:0] FMT_RGB           = 4'd8;
   localparam logic [3:0] FMT_RGB_INT       = 4'd9;
   localparam logic [3:0] FMT_RGBA          = 4'd10;
   localparam logic [3:0] FMT_RGBA_INT      = 4'd11;
   localparam logic [3:0] FMT_DEPTH_STENCIL = 4'd12;

   // Type codes
   localparam logic [4:0] TYPE_UBYTE       = 5'd0;
   localparam logic [4:0] TYPE_BYTE        = 5'd1;
   localparam logic [4:0] TYPE_USHORT      = 5'd2;
   localparam logic [4:0] TYPE_SHORT       = 5'd3;
   localparam logic [4:0] TYPE_HALF        = 5'd4;
   localparam logic [4:0] TYPE_HALF_OES    = 5'd5;
   localparam logic [4:0] TYPE_UINT        = 5'd6;
   localparam logic [4:0] TYPE_INT         = 5'd7;
   localparam logic [4:0] TYPE_FLOAT       = 5'd8;
   localparam logic [4:0] TYPE_565         = 5'd9;
   localparam logic [4:0] TYPE_4444        = 5'd10;
   localparam logic [4:0] TYPE_5551        = 5'd11;
   localparam logic [4:0] TYPE_2_10_10_10  = 5'd12;
   localparam logic [4:0] TYPE_10F_11F_11F = 5'd13;
   localparam logic [4:0] TYPE_5999        = 5'd14;
   localparam logic [4:0] TYPE_24_8        = 5'd15;
   localparam logic [4:0] TYPE_F32_24_8    = 5'd16;

   // Bytes per pixel for a format/type pair, 0 when the pair is not allowed
   function automatic logic [4:0] bytes_per_pixel(input logic [3:0] fmt,
                                                  input logic [4:0] typ);
      logic [4:0] comp;
      logic       fmt_ok;
      logic [4:0] bpp;
      comp   = 5'd0;
      fmt_ok = 1'b1;
      unique case (fmt) inside
         FMT_ALPHA, FMT_LUMINANCE, FMT_RED, FMT_RED_INT, FMT_DEPTH: comp = 5'd1;
         FMT_LUM_ALPHA, FMT_RG, FMT_RG_INT:                       comp = 5'd2;
         FMT_RGB, FMT_RGB_INT:                                    comp = 5'd3;
         FMT_RGBA, FMT_RGBA_INT:                                  comp = 5'd4;
         FMT_DEPTH_STENCIL:                                       comp = 5'd0;
         default:                                                 fmt_ok = 1'b0;
      endcase
      unique case (typ) inside
         TYPE_UBYTE, TYPE_BYTE:                                bpp = comp;
         TYPE_USHORT, TYPE_SHORT, TYPE_HALF, TYPE_HALF_OES:    bpp = comp << 1;
         TYPE_UINT, TYPE_INT, TYPE_FLOAT:                      bpp = comp << 2;
         TYPE_565:            bpp = (fmt == FMT_RGB) ? 5'd2 : 5'd0;
         TYPE_4444, TYPE_5551: bpp = (fmt == FMT_RGBA) ? 5'd2 : 5'd0;
         TYPE_2_10_10_10:
            bpp = (fmt == FMT_RGBA || fmt == FMT_RGBA_INT) ? 5'd4 : 5'd0;
         TYPE_10F_11F_11F, TYPE_5999: bpp = (fmt == FMT_RGB) ? 5'd4 : 5'd0;
         TYPE_24_8:     bpp = (fmt == FMT_DEPTH_STENCIL) ? 5'd4 : 5'd0;
         TYPE_F32_24_8: bpp = (fmt == FMT_DEPTH_STENCIL) ? 5'd8 : 5'd0;
         default:       bpp = 5'd0;
      endcase
      return fmt_ok ? bpp : 5'd0;
   endfunction

   // Stage payloads
   typedef struct packed {
      status_type  status;
      logic        done;     // result settled, byte count is zero
      logic        custom;
      logic        three;
      logic [4:0]  elem;
      logic [3:0]  align;
      logic [15:0] rw;
      logic [15:0] ih;
      logic [16:0] pix_cnt;
      logic [16:0] row_cnt;
      logic [16:0] img_cnt;
   } s1_type;

   typedef struct packed {
      status_type  status;
      logic        done;
      logic        custom;
      logic        three;
      logic [15:0] ih;
      logic [16:0] row_cnt;
      logic [16:0] img_cnt;
      logic [20:0] stride;
      logic [21:0] pix_term;
   } s2_type;

   typedef struct packed {
      status_type  status;
      logic        done;
      logic        custom;
      logic        three;
      logic [16:0] img_cnt;
      logic [36:0] istride;
      logic [37:0] row_term;
      logic [21:0] pix_term;
   } s3_type;

   typedef struct packed {
      status_type  status;
      logic        done;
      logic        custom;
      logic        ovf;
      logic [47:0] img_term;
      logic [38:0] rowpix;
   } s4_type;

endpackage

`default_nettype wire

/* rtl/core/pixel_transfer_size_check.sv */
// Pixel transfer size check: pixel-store registers and a five-stage size pipeline.
// Depends on pts_pkg (codes, stage types, bytes-per-pixel table).
//
// Usage:
//   req_* carries one transfer request per word: width, height, depth, format and
//   type codes in req_tdata, the 3D flag in req_tuser. rsp_* returns one word per
//   request: byte_count and custom_layout in rsp_tdata, status in rsp_tuser.
//   csr_* writes the pixel-store registers (index 0 alignment .. 5 skip images);
//   write them only while no request is in flight. csr_ready is always high.
// Pipeline and throughput:
//   A request accepted on req_* passes through five register stages (decode, row
//   stride, strides and row term, image term, final sum) before its response shows
//   on rsp_*. One word per cycle is sustained while rsp_tready stays high; the stage
//   split is set by the multipliers in stages two to four (up to 17 by 31 bits).
// Reset:
//   Clear all stage valids and load the store defaults (alignment 4, rest 0).
// Back-pressure:
//   When rsp_tready is low the output word holds; each stage advances only into
//   an empty or draining stage, so bubbles close up and req_tready drops only
//   once all five stages are full.
`default_nettype none

module pixel_transfer_size_check (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata, low bit up: width[16:0], height[16:0], depth[16:0],
   //   format_code[3:0], type_code[4:0], zero pad[3:0]
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [63:0] req_tdata,
   // req_tuser: is_three_d
   input  wire logic        req_tuser,
   // rsp_tdata, low bit up: byte_count[30:0], custom_layout
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,
   // rsp_tuser: status[2:0]
   output      logic [2:0]  rsp_tuser,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   // Pixel-store registers
   logic [3:0]  row_alignment_ff;
   logic [15:0] row_length_ff;
   logic [15:0] skip_rows_ff;
   logic [15:0] skip_pixels_ff;
   logic [15:0] image_rows_ff;
   logic [15:0] skip_images_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_alignment_ff <= pts_pkg::ALIGN_RESET;
         row_length_ff    <= '0;
         skip_rows_ff     <= '0;
         skip_pixels_ff   <= '0;
         image_rows_ff    <= '0;
         skip_images_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pts_pkg::REG_ROW_ALIGNMENT: row_alignment_ff <= csr_wdata[3:0];
            pts_pkg::REG_ROW_LENGTH:    row_length_ff    <= csr_wdata;
            pts_pkg::REG_SKIP_ROWS:     skip_rows_ff     <= csr_wdata;
            pts_pkg::REG_SKIP_PIXELS:   skip_pixels_ff   <= csr_wdata;
            pts_pkg::REG_IMAGE_ROWS:    image_rows_ff    <= csr_wdata;
            pts_pkg::REG_SKIP_IMAGES:   skip_images_ff   <= csr_wdata;
            default: ;  // indexes past the list are dropped
         endcase
      end
   end

   // Stage valids and the ready chain running back from the output
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   assign rdy5       = !v5_ff || rsp_tready;
   assign rdy4       = !v4_ff || rdy5;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // Stage 1: decode the request, run the early checks, form the counts
   pts_pkg::s1_type s1_in, s1_ff;

   logic [16:0] w, h, d;
   logic [3:0]  fmt;
   logic [4:0]  typ;
   logic        three;
   logic [4:0]  elem;
   logic        neg, zero, align_ok, custom, overrun;
   logic [15:0] img_h, img_skip, rw, ih;
   logic [16:0] pix_cnt;

   always_comb begin
      w     = req_tdata[16:0];
      h     = req_tdata[33:17];
      d     = req_tdata[50:34];
      fmt   = req_tdata[54:51];
      typ   = req_tdata[59:55];
      three = req_tuser;

      elem     = pts_pkg::bytes_per_pixel(fmt, typ);
      neg      = w[16] || h[16] || d[16];
      zero     = (w == '0) || (h == '0) || (d == '0);
      align_ok = (row_alignment_ff == 4'd1) || (row_alignment_ff == 4'd2) ||
                 (row_alignment_ff == 4'd4) || (row_alignment_ff == 4'd8);

      img_h    = three ? image_rows_ff  : 16'd0;
      img_skip = three ? skip_images_ff : 16'd0;
      custom   = (row_length_ff != '0) || (skip_rows_ff != '0) ||
                 (skip_pixels_ff != '0) || (img_h != '0) || (img_skip != '0);

      rw      = (row_length_ff != '0) ? row_length_ff : w[15:0];
      ih      = (img_h != '0) ? img_h : h[15:0];
      pix_cnt = {1'b0, skip_pixels_ff} + {1'b0, w[15:0]};
      overrun = (pix_cnt > {1'b0, rw}) ||
                (three && ({1'b0, skip_rows_ff} + {1'b0, h[15:0]} > {1'b0, ih}));

      s1_in.status  = pts_pkg::STATUS_OK;
      s1_in.done    = 1'b1;
      s1_in.custom  = 1'b0;
      if (neg) begin
         s1_in.status = pts_pkg::STATUS_NEG_EXTENT;
      end else if (elem == '0) begin
         s1_in.status = pts_pkg::STATUS_BAD_LAYOUT;
      end else if (typ == pts_pkg::TYPE_F32_24_8) begin
         s1_in.status = pts_pkg::STATUS_FORBIDDEN_TYPE;
      end else if (!align_ok) begin
         s1_in.status = pts_pkg::STATUS_BAD_STORE;
      end else if (zero) begin
         s1_in.custom = custom;
      end else if (overrun) begin
         s1_in.status = pts_pkg::STATUS_SKIP_OVERRUN;
         s1_in.custom = custom;
      end else begin
         s1_in.done   = 1'b0;
         s1_in.custom = custom;
      end

      s1_in.three   = three;
      s1_in.elem    = elem;
      s1_in.align   = row_alignment_ff;
      s1_in.rw      = rw;
      s1_in.ih      = ih;
      s1_in.pix_cnt = pix_cnt;
      // counts minus one; only used when the extent is nonzero
      s1_in.row_cnt = {1'b0, skip_rows_ff} + {1'b0, h[15:0]} - 17'd1;
      s1_in.img_cnt = three ? ({1'b0, img_skip} + {1'b0, d[15:0]} - 17'd1) : 17'd0;
   end

   always_ff @(posedge clock) begin
      if (rdy1) s1_ff <= s1_in;
   end

   // Stage 2: row bytes, padded row stride, last-row pixel bytes
   pts_pkg::s2_type s2_in, s2_ff;
   logic [20:0] line, align_m1;

   always_comb begin
      line     = 21'(s1_ff.rw) * 21'(s1_ff.elem);
      align_m1 = 21'(s1_ff.align) - 21'd1;

      s2_in.status   = s1_ff.status;
      s2_in.done     = s1_ff.done;
      s2_in.custom   = s1_ff.custom;
      s2_in.three    = s1_ff.three;
      s2_in.ih       = s1_ff.ih;
      s2_in.row_cnt  = s1_ff.row_cnt;
      s2_in.img_cnt  = s1_ff.img_cnt;
      s2_in.stride   = (line + align_m1) & ~align_m1;
      s2_in.pix_term = 22'(s1_ff.pix_cnt) * 22'(s1_ff.elem);
   end

   always_ff @(posedge clock) begin
      if (rdy2) s2_ff <= s2_in;
   end

   // Stage 3: image stride and skipped-row bytes
   pts_pkg::s3_type s3_in, s3_ff;

   always_comb begin
      s3_in.status   = s2_ff.status;
      s3_in.done     = s2_ff.done;
      s3_in.custom   = s2_ff.custom;
      s3_in.three    = s2_ff.three;
      s3_in.img_cnt  = s2_ff.img_cnt;
      s3_in.istride  = 37'(s2_ff.ih) * 37'(s2_ff.stride);
      s3_in.row_term = 38'(s2_ff.row_cnt) * 38'(s2_ff.stride);
      s3_in.pix_term = s2_ff.pix_term;
   end

   always_ff @(posedge clock) begin
      if (rdy3) s3_ff <= s3_in;
   end

   // Stage 4: skipped-image bytes, row plus pixel terms, flag an image stride past the byte range
   pts_pkg::s4_type s4_in, s4_ff;

   always_comb begin
      s4_in.status   = s3_ff.status;
      s4_in.done     = s3_ff.done;
      s4_in.custom   = s3_ff.custom;
      s4_in.ovf      = s3_ff.three && (s3_ff.istride[36:31] != '0);
      s4_in.img_term = 48'(s3_ff.img_cnt) * 48'(s3_ff.istride[30:0]);
      s4_in.rowpix   = 39'(s3_ff.row_term) + 39'(s3_ff.pix_term);
   end

   always_ff @(posedge clock) begin
      if (rdy4) s4_ff <= s4_in;
   end

   // Stage 5: final sum and range check into the output register
   pts_pkg::status_type status_in, status_ff;
   logic [30:0] byte_count_in, byte_count_ff;
   logic        custom_ff;
   logic [48:0] total;

   always_comb begin
      total = 49'(s4_ff.img_term) + 49'(s4_ff.rowpix);
      if (s4_ff.done) begin
         status_in     = s4_ff.status;
         byte_count_in = '0;
      end else if (s4_ff.ovf || (total[48:31] != '0)) begin
         status_in     = pts_pkg::STATUS_RANGE;
         byte_count_in = '0;
      end else begin
         status_in     = pts_pkg::STATUS_OK;
         byte_count_in = total[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         status_ff     <= status_in;
         byte_count_ff <= byte_count_in;
         custom_ff     <= s4_ff.custom;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {custom_ff, byte_count_ff};
   assign rsp_tuser  = status_ff;

endmodule

`default_nettype wire
